// ----- rtl/stt_pkg.sv -----
// Shared types, token codes and keyword table of the source text tokenizer.
package stt_pkg;

    localparam int OFFSET_WIDTH_DEF  = 16;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [2:0] KIND_EOF      = 3'd0;
    localparam logic [2:0] KIND_IDENT    = 3'd1;
    localparam logic [2:0] KIND_KEYWORD  = 3'd2;
    localparam logic [2:0] KIND_NUMBER   = 3'd3;
    localparam logic [2:0] KIND_STRING   = 3'd4;
    localparam logic [2:0] KIND_OPERATOR = 3'd5;
    localparam logic [2:0] KIND_PUNCT    = 3'd6;

    localparam logic [2:0] KW_NONE = 3'd0;

    localparam int KW_COUNT = 5;
    localparam int KW_MAX   = 6;

    // keyword text, first character in the low byte; order: if else while for return
    localparam logic [KW_COUNT-1:0][8*KW_MAX-1:0] KW_TEXT = {
        48'h6e72_7574_6572,
        48'h0000_0072_6f66,
        48'h0065_6c69_6877,
        48'h0000_6573_6c65,
        48'h0000_0000_6669
    };
    localparam logic [KW_COUNT-1:0][2:0] KW_LEN = {3'd6, 3'd3, 3'd5, 3'd4, 3'd2};

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [2:0]  kw;
        logic [7:0]  sym;
    } t_token;

    // all tokens caused by one input item
    typedef struct packed {
        logic [1:0]       cnt;
        t_token [2:0]     recs;
    } t_group;

endpackage

// ----- rtl/stt_front.sv -----
// Front end: classifies each byte, tracks the open token and builds its token group.
module stt_front #(
    parameter int OFFSET_WIDTH  = stt_pkg::OFFSET_WIDTH_DEF,
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char_byte,
    input  logic           i_last,
    output logic           o_push,
    output stt_pkg::t_group o_group
);
    import stt_pkg::*;

    localparam int OW = OFFSET_WIDTH;
    localparam int K  = KEYWORD_CHARS;
    localparam int CW = $clog2(K + 2);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_ENDED  = 3'd4;

    logic [2:0]          r_mode, n_mode;
    logic [OW-1:0]       r_pos, n_pos;
    logic [OW-1:0]       r_start, n_start;
    logic [K-1:0][7:0]   r_buf, n_buf;
    logic [CW-1:0]       r_cnt, n_cnt;
    t_group              n_group;

    function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] v);
        return (v == {OW{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] clip(input logic [OW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic t_token mk_tok(input logic [2:0] kind, input logic [OW-1:0] s,
                                      input logic [OW-1:0] e, input logic [2:0] kw,
                                      input logic [7:0] sym);
        t_token t;
        t.kind  = kind;
        t.start = clip(s);
        t.len   = clip((e >= s) ? e - s : '0);
        t.kw    = kw;
        t.sym   = sym;
        return t;
    endfunction

    function automatic logic [2:0] kw_of(input logic [K-1:0][7:0] b, input logic [CW-1:0] cnt);
        logic [2:0] id;
        logic       m;
        id = KW_NONE;
        for (int k = 0; k < KW_COUNT; k++) begin
            m = (cnt == CW'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX; i++) begin
                if (3'(i) < KW_LEN[k] && b[i] != KW_TEXT[k][8*i +: 8]) begin
                    m = 1'b0;
                end
            end
            if (m && id == KW_NONE) begin
                id = 3'(k + 1);
            end
        end
        return id;
    endfunction

    function automatic t_token open_tok(input logic [2:0] mode, input logic [OW-1:0] s,
                                        input logic [OW-1:0] e, input logic [2:0] kw);
        logic [2:0] kind;
        if (mode == MODE_IDENT) begin
            kind = (kw != KW_NONE) ? KIND_KEYWORD : KIND_IDENT;
        end else if (mode == MODE_NUMBER) begin
            kind = KIND_NUMBER;
        end else begin
            kind = KIND_STRING;
        end
        return mk_tok(kind, s, e, (mode == MODE_IDENT) ? kw : KW_NONE, 8'h00);
    endfunction

    always_comb begin
        logic [7:0]    c;
        logic          is_alpha, is_digit, is_space, is_op, is_punct;
        logic          used, term, is_open;
        logic [OW-1:0] p, p1;
        logic [2:0]    kw;
        t_token [3:0]  cand;
        logic [3:0]    cv;
        logic [1:0]    k;

        c        = i_char_byte;
        is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
        is_digit = (c >= "0" && c <= "9");
        is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
        is_op    = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=");
        is_punct = (c == ";") || (c == ",") || (c == "(") || (c == ")") ||
                   (c == "{") || (c == "}");
        p        = r_pos;
        p1       = sat_inc(r_pos);
        used     = 1'b0;
        term     = 1'b0;
        is_open  = 1'b0;
        cand     = '0;
        cv       = '0;
        kw       = KW_NONE;

        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_buf   = r_buf;
        n_cnt   = r_cnt;

        if (r_mode == MODE_ENDED) begin
            if (i_last) begin
                n_mode  = MODE_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_buf   = '0;
                n_cnt   = '0;
            end
        end else begin
            unique case (r_mode)
                MODE_IDENT: begin
                    if (is_alpha || is_digit) begin
                        used = 1'b1;
                        for (int i = 0; i < K; i++) begin
                            if (r_cnt == CW'(i)) begin
                                n_buf[i] = c;
                            end
                        end
                        if (r_cnt <= CW'(K)) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        term = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit) begin
                        used = 1'b1;
                    end else begin
                        term = 1'b1;
                    end
                end
                MODE_STRING: begin
                    used = 1'b1;
                    term = (c == "\"");
                end
                default: begin
                end
            endcase

            if (term) begin
                cand[0] = open_tok(r_mode, r_start, p, kw_of(r_buf, r_cnt));
                cv[0]   = 1'b1;
                n_mode  = MODE_IDLE;
            end

            if (!used) begin
                priority if (is_space) begin
                end else if (c == 8'h00) begin
                    cand[1] = mk_tok(KIND_EOF, p, p, KW_NONE, 8'h00);
                    cv[1]   = 1'b1;
                    n_mode  = MODE_ENDED;
                end else if (is_alpha) begin
                    n_mode   = MODE_IDENT;
                    n_start  = p;
                    n_buf    = '0;
                    n_buf[0] = c;
                    n_cnt    = CW'(1);
                end else if (is_digit) begin
                    n_mode  = MODE_NUMBER;
                    n_start = p;
                end else if (c == "\"") begin
                    n_mode  = MODE_STRING;
                    n_start = p1;
                end else if (is_op) begin
                    cand[1] = mk_tok(KIND_OPERATOR, p, p1, KW_NONE, c);
                    cv[1]   = 1'b1;
                end else if (is_punct) begin
                    cand[1] = mk_tok(KIND_PUNCT, p, p1, KW_NONE, c);
                    cv[1]   = 1'b1;
                end else begin
                    cand[1] = mk_tok(KIND_EOF, p, p, KW_NONE, 8'h00);
                    cv[1]   = 1'b1;
                end
            end

            if (i_last) begin
                // flush whatever is still open, then close the text
                if (n_mode != MODE_ENDED) begin
                    is_open = (n_mode == MODE_IDENT) || (n_mode == MODE_NUMBER) ||
                              (n_mode == MODE_STRING);
                    kw      = kw_of(n_buf, n_cnt);
                    cand[2] = open_tok(n_mode, n_start, p1, kw);
                    cv[2]   = is_open;
                    cand[3] = mk_tok(KIND_EOF, p1, p1, KW_NONE, 8'h00);
                    cv[3]   = 1'b1;
                end
                n_mode  = MODE_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_buf   = '0;
                n_cnt   = '0;
            end else begin
                n_pos = p1;
            end
        end

        // pack the valid candidates in order
        n_group = '0;
        k       = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i] && k != 2'd3) begin
                n_group.recs[k] = cand[i];
                k = k + 2'd1;
            end
        end
        n_group.cnt = k;
    end

    assign o_push  = i_accept && (n_group.cnt != 2'd0);
    assign o_group = n_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_buf   <= '0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
        end
    end

    a_ended_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ENDED) |-> !o_push)
        else $error("token pushed after end of text");

    a_start_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDENT || r_mode == MODE_NUMBER) |-> (r_start <= r_pos))
        else $error("open token starts past the current byte");

endmodule

// ----- rtl/stt_queue.sv -----
// Short queue of token groups between the front end and the output stage.
module stt_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stt_pkg::t_group i_group,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output stt_pkg::t_group o_head
);
    import stt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group           r_slot [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- rtl/stt_back.sv -----
// Output stage: walks the head token group and hands out one token per pop.
module stt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  stt_pkg::t_group i_head,
    input  logic            i_pop,
    output logic            o_head_pop,
    output logic            o_empty,
    output logic [2:0]      o_token_kind,
    output logic [15:0]     o_start_offset,
    output logic [15:0]     o_token_length,
    output logic [2:0]      o_keyword_id,
    output logic [7:0]      o_symbol_byte,
    output logic            o_last_of_run
);
    import stt_pkg::*;

    logic [1:0] r_sub;
    t_token     tok;
    logic       is_last;
    logic       take;

    assign tok     = i_head.recs[r_sub];
    assign is_last = (r_sub == i_head.cnt - 2'd1);
    assign take    = i_pop && i_head_valid;

    assign o_empty        = !i_head_valid;
    assign o_token_kind   = tok.kind;
    assign o_start_offset = tok.start;
    assign o_token_length = tok.len;
    assign o_keyword_id   = tok.kw;
    assign o_symbol_byte  = tok.sym;
    assign o_last_of_run  = is_last;
    assign o_head_pop     = take && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (take) begin
            r_sub <= is_last ? 2'd0 : r_sub + 2'd1;
        end
    end

    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (i_head.cnt != 2'd0))
        else $error("empty token group in queue");

    a_sub_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_sub < i_head.cnt))
        else $error("token index past group size");

    a_group_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0) |-> $stable(i_head))
        else $error("head group changed while partly delivered");

endmodule

// ----- rtl/source_text_tokenizer_core.sv -----
// Top level of the byte-serial source text tokenizer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  text    | in        | push / full            | i_char_byte, i_last
//  tokens  | out       | empty / pop            | o_token_kind, o_start_offset, o_token_length,
//          |           |                        | o_keyword_id, o_symbol_byte, o_last_of_run
//
// One byte is taken per cycle while full is low; the front end classifies it in the cycle it is accepted.
// A byte yields zero to three tokens, handed out one per pop, so the token port bounds
// throughput when bytes produce more than one token each.
// A queue of QUEUE_DEPTH token groups sits between front end and output; full rises when
// it fills, and an output stall only stops input once it is full.
// Reset is synchronous and active low; no clearing pass, the block is ready right after.
module source_text_tokenizer_core #(
    parameter int OFFSET_WIDTH  = stt_pkg::OFFSET_WIDTH_DEF,
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
    parameter int QUEUE_DEPTH   = stt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [2:0]  o_keyword_id,
    output logic [7:0]  o_symbol_byte,
    output logic        o_last_of_run
);
    import stt_pkg::*;

    logic   accept;
    logic   grp_push;
    t_group grp_in;
    t_group head;
    logic   q_empty;
    logic   head_pop;

    assign accept = push && !full;

    stt_front #(
        .OFFSET_WIDTH  (OFFSET_WIDTH),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_byte (i_char_byte),
        .i_last      (i_last),
        .o_push      (grp_push),
        .o_group     (grp_in)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (grp_push),
        .i_group (grp_in),
        .i_pop   (head_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    stt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (!q_empty),
        .i_head         (head),
        .i_pop          (pop),
        .o_head_pop     (head_pop),
        .o_empty        (empty),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_keyword_id   (o_keyword_id),
        .o_symbol_byte  (o_symbol_byte),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
